### design/pixel_block_binning_macros.svh
// Assertion macros shared by the pixel binning RTL.
`ifndef PIXEL_BLOCK_BINNING_MACROS_SVH
`define PIXEL_BLOCK_BINNING_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define PBB_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### design/pbb_pkg.sv
// Shared constants and types of the pixel binning block.
`default_nettype none

package pbb_pkg;

    // item field widths
    localparam int PIX_W      = 16;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;

    // configuration register widths
    localparam int BF_W       = 4;
    localparam int LW_W       = 13;
    localparam int FR_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd2;

    // register reset values
    localparam int BF_RST = 6;
    localparam int LW_RST = 2255;
    localparam int FR_RST = 3791;

    // row limit (frame_rows saturates here)
    localparam int MAX_ROWS = 4096;

    // defaults of the top-level parameters
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_BIN   = 8;

    // what to do with a finished square row
    typedef struct packed {
        logic emit;      // bottom row of the square: send result
        logic wr;        // any row above the bottom: write partial sum back
        logic use_prev;  // add the stored partial sum
        logic last;      // last binned pixel of the frame
    } t_acc_ctl;

endpackage

`default_nettype wire

### design/pixel_block_binning.sv
// Top level of the square pixel binning block.
//
//  channel   dir  handshake                    payload
//  --------  ---  ---------------------------  ---------------------------------------
//  pixel     in   i_pix_valid / o_pix_ready    i_pixel_value
//  binned    out  o_bin_valid / i_bin_ready    o_binned_value, o_out_col, o_out_row,
//                                              o_frame_last
//  config    in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Sustained rate is one pixel item per cycle while intake is not stalled. A
// binned item passes the accumulate stage register, then the output register,
// once the pixel closing its square is taken. The line store is read when a
// square row closes and written back in the next cycle by the accumulate stage;
// the same column entry is touched again only a full line later, so read and
// write never collide. Pixel intake stalls only while a finished result sits
// in the accumulate stage and the output register is still full.
// Reset (synchronous, active low) clears counters, phases and handshake state;
// the line store has no clearing pass since every entry is written before it
// is read. A register write restarts the frame counters; config is always ready.
`default_nettype none
`include "pixel_block_binning_macros.svh"

module pixel_block_binning #(
    parameter int MAX_WIDTH = pbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BIN   = pbb_pkg::DEF_MAX_BIN
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pbb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pbb_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    input  wire logic                             i_pix_valid,
    output logic                                  o_pix_ready,
    input  wire logic [pbb_pkg::PIX_W-1:0]        i_pixel_value,

    output logic                                  o_bin_valid,
    input  wire logic                             i_bin_ready,
    output logic      [pbb_pkg::PIX_W-1:0]        o_binned_value,
    output logic      [pbb_pkg::COL_W-1:0]        o_out_col,
    output logic      [pbb_pkg::ROW_W-1:0]        o_out_row,
    output logic                                  o_frame_last
);

    localparam int OC_W  = $clog2(MAX_WIDTH);
    // only bin factors of two or more use the store, so half a line suffices
    localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int AW    = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;

    logic                          pix_accept;
    logic                          cmd_valid;
    pbb_pkg::t_acc_ctl             cmd;
    logic [pbb_pkg::PIX_W-1:0]     hsum;
    logic [OC_W-1:0]               oc;
    logic [pbb_pkg::ROW_W-1:0]     orow;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [pbb_pkg::PIX_W-1:0]     rd_data;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [pbb_pkg::PIX_W-1:0]     wr_data;

    assign o_cfg_ready = 1'b1;
    assign pix_accept  = i_pix_valid && o_pix_ready;

    // position counters, horizontal sum, store read issue
    pbb_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BIN   (MAX_BIN)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pix_accept  (pix_accept),
        .i_pixel_value (i_pixel_value),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .o_hsum        (hsum),
        .o_oc          (oc),
        .o_orow        (orow),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr)
    );

    // per-output-column partial sums
    pbb_ram #(
        .WIDTH (pbb_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // add, write back or emit
    pbb_accum #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .i_hsum         (hsum),
        .i_oc           (oc),
        .i_orow         (orow),
        .o_cmd_ready    (o_pix_ready),
        .i_rd_data      (rd_data),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_bin_valid    (o_bin_valid),
        .i_bin_ready    (i_bin_ready),
        .o_binned_value (o_binned_value),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_frame_last   (o_frame_last)
    );

    `PBB_ASSERT_IMP(a_rw_conflict, i_clk, i_rst_n, rd_en && wr_en, rd_addr != wr_addr, "line store read and write hit same entry")
    `PBB_ASSERT_IMP(a_rd_on_accept, i_clk, i_rst_n, rd_en, pix_accept, "line store read without pixel item")
    `PBB_ASSERT_IMP(a_no_cfg_busy, i_clk, i_rst_n, i_cfg_valid, !pix_accept, "config write during pixel item")

endmodule

`default_nettype wire

### design/pbb_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/pbb_ctrl.sv
// Pixel position tracking, horizontal sum and line store read issue.
`default_nettype none
`include "pixel_block_binning_macros.svh"

module pbb_ctrl #(
    parameter int MAX_WIDTH = pbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BIN   = pbb_pkg::DEF_MAX_BIN,
    localparam int OC_W     = $clog2(MAX_WIDTH),
    localparam int AW       = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [pbb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pbb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_pix_accept,
    input  wire logic [pbb_pkg::PIX_W-1:0]        i_pixel_value,
    output logic                                  o_cmd_valid,
    output pbb_pkg::t_acc_ctl                     o_cmd,
    output logic      [pbb_pkg::PIX_W-1:0]        o_hsum,
    output logic      [OC_W-1:0]                  o_oc,
    output logic      [pbb_pkg::ROW_W-1:0]        o_orow,
    output logic                                  o_rd_en,
    output logic      [AW-1:0]                    o_rd_addr
);

    localparam int WW   = OC_W + 1;
    localparam int PH_W = $clog2(MAX_BIN);
    localparam int B_W  = $clog2(MAX_BIN + 1);
    localparam int HW   = pbb_pkg::FR_W;
    localparam int RW   = pbb_pkg::ROW_W;
    localparam int XW   = ((WW > B_W) ? WW : B_W) + 1;
    localparam int YW   = ((HW > B_W) ? HW : B_W) + 1;

    localparam logic [B_W-1:0] RST_B =
        B_W'((pbb_pkg::BF_RST > MAX_BIN) ? MAX_BIN : pbb_pkg::BF_RST);
    localparam logic [WW-1:0] RST_W =
        WW'((pbb_pkg::LW_RST > MAX_WIDTH) ? MAX_WIDTH : pbb_pkg::LW_RST);
    localparam logic [HW-1:0] RST_H =
        HW'((pbb_pkg::FR_RST > pbb_pkg::MAX_ROWS) ? pbb_pkg::MAX_ROWS : pbb_pkg::FR_RST);

    // saturate register writes once, on the way in; zero reads as one
    function automatic logic [B_W-1:0] clamp_bin(input logic [pbb_pkg::BF_W-1:0] v);
        if (v == '0) begin
            return B_W'(1);
        end else if (int'(v) > MAX_BIN) begin
            return B_W'(MAX_BIN);
        end
        return B_W'(v);
    endfunction

    function automatic logic [WW-1:0] clamp_width(input logic [pbb_pkg::LW_W-1:0] v);
        if (v == '0) begin
            return WW'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            return WW'(MAX_WIDTH);
        end
        return WW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_rows(input logic [pbb_pkg::FR_W-1:0] v);
        if (v == '0) begin
            return HW'(1);
        end else if (int'(v) > pbb_pkg::MAX_ROWS) begin
            return HW'(pbb_pkg::MAX_ROWS);
        end
        return HW'(v);
    endfunction

    logic [B_W-1:0]             r_b, n_b;
    logic [WW-1:0]              r_w, n_w;
    logic [HW-1:0]              r_h, n_h;
    logic [OC_W-1:0]            r_col, n_col;
    logic [RW-1:0]              r_row, n_row;
    logic [PH_W-1:0]            r_cph, n_cph;
    logic [PH_W-1:0]            r_rph, n_rph;
    logic [pbb_pkg::PIX_W-1:0]  r_hsum, n_hsum;
    logic [OC_W-1:0]            r_oc, n_oc;
    logic [RW-1:0]              r_orow, n_orow;
    logic                       r_col_fit, n_col_fit;
    logic                       r_row_fit, n_row_fit;

    logic                       col_in;
    logic                       row_in;
    logic                       in_reg;
    logic                       cph_end;
    logic                       rph_end;
    logic                       nxt_col_fit;
    logic                       nxt_row_fit;
    logic                       col_wrap;
    logic                       row_wrap;
    logic                       sq_done;
    logic                       cfg_hit;
    logic [pbb_pkg::PIX_W-1:0]  hsum_new;

    // square fits when it starts: checked from config at column/row zero,
    // else carried forward from the previous square
    assign col_in      = (r_col == '0) ? (XW'(r_b) <= XW'(r_w)) : r_col_fit;
    assign row_in      = (r_row == '0) ? (YW'(r_b) <= YW'(r_h)) : r_row_fit;
    assign in_reg      = col_in && row_in;
    assign cph_end     = B_W'(r_cph) >= (r_b - B_W'(1));
    assign rph_end     = B_W'(r_rph) >= (r_b - B_W'(1));
    assign nxt_col_fit = (XW'(r_col) + XW'(1) + XW'(r_b)) <= XW'(r_w);
    assign nxt_row_fit = (YW'(r_row) + YW'(1) + YW'(r_b)) <= YW'(r_h);
    assign col_wrap    = (XW'(r_col) + XW'(1)) >= XW'(r_w);
    assign row_wrap    = (YW'(r_row) + YW'(1)) >= YW'(r_h);
    assign hsum_new    = (r_cph == '0) ? i_pixel_value : r_hsum + i_pixel_value;
    assign sq_done     = in_reg && cph_end;

    always_comb begin
        n_b       = r_b;
        n_w       = r_w;
        n_h       = r_h;
        n_col     = r_col;
        n_row     = r_row;
        n_cph     = r_cph;
        n_rph     = r_rph;
        n_hsum    = r_hsum;
        n_oc      = r_oc;
        n_orow    = r_orow;
        n_col_fit = r_col_fit;
        n_row_fit = r_row_fit;
        cfg_hit   = 1'b0;

        if (i_cfg_valid) begin
            cfg_hit = 1'b1;
            unique case (i_cfg_index)
                pbb_pkg::CFG_BIN_FACTOR: n_b = clamp_bin(i_cfg_data[pbb_pkg::BF_W-1:0]);
                pbb_pkg::CFG_LINE_WIDTH: n_w = clamp_width(i_cfg_data[pbb_pkg::LW_W-1:0]);
                pbb_pkg::CFG_FRAME_ROWS: n_h = clamp_rows(i_cfg_data[pbb_pkg::FR_W-1:0]);
                default:                 cfg_hit = 1'b0;
            endcase
        end

        if (cfg_hit) begin
            // any register write restarts the frame
            n_col  = '0;
            n_row  = '0;
            n_cph  = '0;
            n_rph  = '0;
            n_hsum = '0;
            n_oc   = '0;
            n_orow = '0;
        end else if (i_pix_accept) begin
            // the rest of the current square keeps its fit
            n_col_fit = col_in;
            if (in_reg) begin
                n_hsum = hsum_new;
                if (cph_end) begin
                    n_cph     = '0;
                    n_oc      = r_oc + OC_W'(1);
                    n_col_fit = nxt_col_fit;
                end else begin
                    n_cph = r_cph + PH_W'(1);
                end
            end
            if (col_wrap) begin
                n_col     = '0;
                n_cph     = '0;
                n_oc      = '0;
                n_row_fit = row_in;
                if (row_in) begin
                    if (rph_end) begin
                        n_rph     = '0;
                        n_orow    = r_orow + RW'(1);
                        n_row_fit = nxt_row_fit;
                    end else begin
                        n_rph = r_rph + PH_W'(1);
                    end
                end
                if (row_wrap) begin
                    n_row  = '0;
                    n_rph  = '0;
                    n_orow = '0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + OC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b       <= RST_B;
            r_w       <= RST_W;
            r_h       <= RST_H;
            r_col     <= '0;
            r_row     <= '0;
            r_cph     <= '0;
            r_rph     <= '0;
            r_hsum    <= '0;
            r_oc      <= '0;
            r_orow    <= '0;
            r_col_fit <= 1'b0;
            r_row_fit <= 1'b0;
        end else begin
            r_b       <= n_b;
            r_w       <= n_w;
            r_h       <= n_h;
            r_col     <= n_col;
            r_row     <= n_row;
            r_cph     <= n_cph;
            r_rph     <= n_rph;
            r_hsum    <= n_hsum;
            r_oc      <= n_oc;
            r_orow    <= n_orow;
            r_col_fit <= n_col_fit;
            r_row_fit <= n_row_fit;
        end
    end

    assign o_cmd_valid    = i_pix_accept && sq_done;
    assign o_cmd.emit     = rph_end;
    assign o_cmd.wr       = !rph_end;
    assign o_cmd.use_prev = (r_rph != '0);
    assign o_cmd.last     = !nxt_col_fit && !nxt_row_fit;
    assign o_hsum         = hsum_new;
    assign o_oc           = r_oc;
    assign o_orow         = r_orow;
    assign o_rd_en        = o_cmd_valid && o_cmd.use_prev;
    assign o_rd_addr      = r_oc[AW-1:0];

    `PBB_ASSERT_ALWAYS(a_cph_range, i_clk, i_rst_n, B_W'(r_cph) < r_b, "column phase beyond bin factor")
    `PBB_ASSERT_ALWAYS(a_col_range, i_clk, i_rst_n, XW'(r_col) < XW'(r_w), "column count beyond line width")
    `PBB_ASSERT_IMP(a_rd_row, i_clk, i_rst_n, o_rd_en, r_b > B_W'(1), "line store read with bin factor one")

endmodule

`default_nettype wire

### design/pbb_accum.sv
// Line store add and write-back stage plus result output register.
`default_nettype none
`include "pixel_block_binning_macros.svh"

module pbb_accum #(
    parameter int MAX_WIDTH = pbb_pkg::DEF_MAX_WIDTH,
    localparam int OC_W     = $clog2(MAX_WIDTH),
    localparam int AW       = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire pbb_pkg::t_acc_ctl             i_cmd,
    input  wire logic [pbb_pkg::PIX_W-1:0]     i_hsum,
    input  wire logic [OC_W-1:0]               i_oc,
    input  wire logic [pbb_pkg::ROW_W-1:0]     i_orow,
    output logic                               o_cmd_ready,
    input  wire logic [pbb_pkg::PIX_W-1:0]     i_rd_data,
    output logic                               o_wr_en,
    output logic      [AW-1:0]                 o_wr_addr,
    output logic      [pbb_pkg::PIX_W-1:0]     o_wr_data,
    output logic                               o_bin_valid,
    input  wire logic                          i_bin_ready,
    output logic      [pbb_pkg::PIX_W-1:0]     o_binned_value,
    output logic      [pbb_pkg::COL_W-1:0]     o_out_col,
    output logic      [pbb_pkg::ROW_W-1:0]     o_out_row,
    output logic                               o_frame_last
);

    logic                          r_s_valid;
    pbb_pkg::t_acc_ctl             r_s_ctl;
    logic [pbb_pkg::PIX_W-1:0]     r_s_hsum;
    logic [OC_W-1:0]               r_s_oc;
    logic [pbb_pkg::ROW_W-1:0]     r_s_orow;

    logic                          r_o_valid;
    logic [pbb_pkg::PIX_W-1:0]     r_o_value;
    logic [pbb_pkg::COL_W-1:0]     r_o_col;
    logic [pbb_pkg::ROW_W-1:0]     r_o_row;
    logic                          r_o_last;

    logic                          out_free;
    logic                          s_go;
    logic [pbb_pkg::PIX_W-1:0]     sum;

    assign out_free    = !r_o_valid || i_bin_ready;
    // write-back items never wait; results wait for a free output slot
    assign s_go        = r_s_valid && (!r_s_ctl.emit || out_free);
    assign o_cmd_ready = !r_s_valid || s_go;
    assign sum         = (r_s_ctl.use_prev ? i_rd_data : '0) + r_s_hsum;

    assign o_wr_en   = s_go && r_s_ctl.wr;
    assign o_wr_addr = r_s_oc[AW-1:0];
    assign o_wr_data = sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd_valid && o_cmd_ready) begin
                r_s_valid <= 1'b1;
            end else if (s_go) begin
                r_s_valid <= 1'b0;
            end
            if (s_go && r_s_ctl.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_bin_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid && o_cmd_ready) begin
            r_s_ctl  <= i_cmd;
            r_s_hsum <= i_hsum;
            r_s_oc   <= i_oc;
            r_s_orow <= i_orow;
        end
        if (s_go && r_s_ctl.emit) begin
            r_o_value <= sum;
            r_o_col   <= pbb_pkg::COL_W'(r_s_oc);
            r_o_row   <= r_s_orow;
            r_o_last  <= r_s_ctl.last;
        end
    end

    assign o_bin_valid    = r_o_valid;
    assign o_binned_value = r_o_value;
    assign o_out_col      = r_o_col;
    assign o_out_row      = r_o_row;
    assign o_frame_last   = r_o_last;

    `PBB_ASSERT_IMP(a_wr_no_stall, i_clk, i_rst_n, r_s_valid && !r_s_ctl.emit, o_cmd_ready, "write-back item stalled")
    `PBB_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, r_s_valid && r_s_ctl.emit && r_o_valid && !i_bin_ready, !o_cmd_ready, "item taken while result slot full")
    `PBB_ASSERT_IMP(a_one_action, i_clk, i_rst_n, r_s_valid, r_s_ctl.emit != r_s_ctl.wr, "square row neither emits nor writes back")

endmodule

`default_nettype wire

### bench/pixel_block_binning_tb.sv
// Self-checking testbench for the square pixel binning block.
module pixel_block_binning_tb;

    // Run limits and traffic shaping
    localparam int CYCLE_LIMIT  = 50000;  // several times the slowest clean run
    localparam int RANDOM_ITEMS = 850;    // random pixel items before the big-extent tests
    localparam int STEADY_ITEMS = 300;    // opening random stretch with no idling on either side
    localparam int IDLE_PCT     = 22;     // percent of cycles a side sits idle
    localparam int DRAIN_CYCLES = 6;      // margin for pixels in flight with no result pending
    localparam int HOLD_CYCLES  = 200;    // long receiver hold-off in the backpressure test
    localparam int REPORT_CAP   = 100;    // keep the log readable if things go badly wrong
    localparam int SLICE_ITEMS  = 120;    // pixels sent into each big-extent frame
    localparam int STORE_DEPTH  = pbb_pkg::DEF_MAX_WIDTH / 2;

    // Register index that decodes to nothing
    localparam logic [pbb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One binned pixel as it leaves the block
    typedef struct {
        logic [pbb_pkg::PIX_W-1:0] value;
        logic [pbb_pkg::COL_W-1:0] col;
        logic [pbb_pkg::ROW_W-1:0] row;
        logic                      last;
    } t_binned_pix;

    // DUT connections
    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [pbb_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pbb_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_pix_valid;
    logic                           o_pix_ready;
    logic [pbb_pkg::PIX_W-1:0]      i_pixel_value;
    logic                           o_bin_valid;
    logic                           i_bin_ready;
    logic [pbb_pkg::PIX_W-1:0]      o_binned_value;
    logic [pbb_pkg::COL_W-1:0]      o_out_col;
    logic [pbb_pkg::ROW_W-1:0]      o_out_row;
    logic                           o_frame_last;

    // Predictor state: registers, position counters, running sums, line store
    logic [pbb_pkg::BF_W-1:0]  cfg_bin;
    logic [pbb_pkg::LW_W-1:0]  cfg_width;
    logic [pbb_pkg::FR_W-1:0]  cfg_rows;
    int unsigned               col_cnt, row_cnt, col_ph, row_ph;
    logic [pbb_pkg::PIX_W-1:0] hsum;
    bit   [pbb_pkg::PIX_W-1:0] line_sums [STORE_DEPTH];

    // Binned pixels predicted but not yet seen on the output
    t_binned_pix expected_bins[$];

    // Bookkeeping shared by the stimulus, the sink and the checker
    int  errors       = 0;
    int  pixels_sent  = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  cycle_count  = 0;
    int  sink_hold    = 0;  // cycles the receiver still has to hold off
    bit  steady       = 1'b0; // no idling on either side while set

    pixel_block_binning uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pix_valid    (i_pix_valid),
        .o_pix_ready    (o_pix_ready),
        .i_pixel_value  (i_pixel_value),
        .o_bin_valid    (o_bin_valid),
        .i_bin_ready    (i_bin_ready),
        .o_binned_value (o_binned_value),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_frame_last   (o_frame_last)
    );

    // 8-unit clock period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends up here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_bins.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Zero reads as 1, anything past the limit saturates
    function automatic int unsigned clamp_field(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic restart_frame();
        col_cnt = 0;
        row_cnt = 0;
        col_ph  = 0;
        row_ph  = 0;
        hsum    = '0;
    endtask

    // Any decoded register write restarts the frame; the unused index does nothing
    task automatic apply_reg(input logic [pbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pbb_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            pbb_pkg::CFG_BIN_FACTOR: begin
                cfg_bin = data[pbb_pkg::BF_W-1:0];
                restart_frame();
            end
            pbb_pkg::CFG_LINE_WIDTH: begin
                cfg_width = data[pbb_pkg::LW_W-1:0];
                restart_frame();
            end
            pbb_pkg::CFG_FRAME_ROWS: begin
                cfg_rows = data[pbb_pkg::FR_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
    endtask

    // Advance the predictor by one accepted pixel; queue the binned pixel it closes
    task automatic bin_pixel(input logic [pbb_pkg::PIX_W-1:0] pix);
        int unsigned b, w, h, ocols, orows, oc, orow;
        logic [pbb_pkg::PIX_W-1:0] prev, total;
        t_binned_pix res;
        b = clamp_field(cfg_bin, pbb_pkg::DEF_MAX_BIN);
        w = clamp_field(cfg_width, pbb_pkg::DEF_MAX_WIDTH);
        h = clamp_field(cfg_rows, pbb_pkg::MAX_ROWS);
        ocols = w / b;
        orows = h / b;
        // pixels of a partial right-hand square or partial bottom block row fall through
        if (col_cnt < ocols * b && row_cnt < orows * b) begin
            oc   = col_cnt / b;
            orow = row_cnt / b;
            hsum = (col_ph == 0) ? pix : hsum + pix;
            if (col_ph >= b - 1) begin
                // square row closed: fold in the partial sum from the rows above
                prev = '0;
                if (row_ph != 0 && oc < STORE_DEPTH)
                    prev = line_sums[oc];
                total = prev + hsum;
                if (row_ph >= b - 1) begin
                    res.value = total;
                    res.col   = oc[pbb_pkg::COL_W-1:0];
                    res.row   = orow[pbb_pkg::ROW_W-1:0];
                    res.last  = (oc == ocols - 1) && (orow == orows - 1);
                    expected_bins.push_back(res);
                end else if (oc < STORE_DEPTH) begin
                    line_sums[oc] = total;
                end
                col_ph = 0;
            end else begin
                col_ph++;
            end
        end
        // position counters; row phase only moves inside the full block rows
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            col_ph  = 0;
            if (row_cnt < orows * b)
                row_ph = (row_ph >= b - 1) ? 0 : row_ph + 1;
            if (row_cnt + 1 >= h) begin
                row_cnt = 0;
                row_ph  = 0;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: receiver readiness and result checking
    // ------------------------------------------------------------------

    // Receiver: random stalls, a counted hold-off on request, none in steady stretches
    initial begin
        i_bin_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                sink_hold   = sink_hold - 1;
                i_bin_ready <= 1'b0;
            end else if (steady) begin
                i_bin_ready <= 1'b1;
            end else begin
                i_bin_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Every accepted result is matched against the oldest prediction
    always @(posedge i_clk) begin
        t_binned_pix want;
        if (i_rst_n && o_bin_valid && i_bin_ready) begin
            if (expected_bins.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none, actual value %0d col %0d row %0d",
                             $time, o_binned_value, o_out_col, o_out_row);
            end else begin
                want = expected_bins.pop_front();
                check_field("binned_value", 32'(want.value), 32'(o_binned_value));
                check_field("out_col", 32'(want.col), 32'(o_out_col));
                check_field("out_row", 32'(want.row), 32'(o_out_row));
                check_field("frame_last", 32'(want.last), 32'(o_frame_last));
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one pixel item, maybe after a random gap, and predict once it is taken.
    // Valid stays up afterwards so back-to-back items go without a gap.
    task automatic send_pixel(input logic [pbb_pkg::PIX_W-1:0] v);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_pix_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_pix_valid   <= 1'b1;
        i_pixel_value <= v;
        @(posedge i_clk);
        while (!o_pix_ready)
            @(posedge i_clk);
        bin_pixel(v);
        pixels_sent++;
    endtask

    // One register write; the caller lowers valid with end_config when done
    task automatic write_reg(input logic [pbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pbb_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic end_config();
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline empty
    // (pixels that close no square can still be in flight).
    task automatic wait_idle();
        i_pix_valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [pbb_pkg::CFG_DATA_W-1:0] bf,
                             input logic [pbb_pkg::CFG_DATA_W-1:0] lw,
                             input logic [pbb_pkg::CFG_DATA_W-1:0] fr);
        write_reg(pbb_pkg::CFG_BIN_FACTOR, bf);
        write_reg(pbb_pkg::CFG_LINE_WIDTH, lw);
        write_reg(pbb_pkg::CFG_FRAME_ROWS, fr);
        end_config();
    endtask

    // Mostly random content, with the all-zero and all-one pixels mixed in
    function automatic logic [pbb_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return pbb_pkg::PIX_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 6x6 squares on a wide line, so a few pixels yield nothing
    task automatic test_after_reset();
        int i;
        for (i = 0; i < 4; i++)
            send_pixel(random_pixel());
        wait_idle();
    endtask

    // Bin factor 1: every pixel comes out as is, extremes of the pixel range
    task automatic test_pass_through();
        set_frame(1, 3, 2);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'hAAAA);
        wait_idle();
    endtask

    // 2x2 squares on a 5x3 frame of full-scale pixels: sums wrap, the odd
    // column and the odd row are dropped
    task automatic test_edge_and_wrap();
        int i;
        set_frame(2, 5, 3);
        for (i = 0; i < 15; i++)
            send_pixel(16'hFFFF);
        wait_idle();
    endtask

    // Receiver holds off while pixels keep coming, so intake has to stall;
    // afterwards the sender pauses until every result is back
    task automatic test_backpressure();
        int i;
        set_frame(1, 7, 5);
        sink_hold = HOLD_CYCLES;
        for (i = 0; i < 60; i++)
            send_pixel(random_pixel());
        wait_idle();
    endtask

    // Random frame settings, mostly small so frames complete, with zero and
    // saturating register values, stray upper bits, partial rewrites that
    // restart the frame mid-way, and writes to the unused index
    task automatic test_random_frames();
        int n, i, sent;
        logic [pbb_pkg::CFG_DATA_W-1:0] bf, lw, fr;
        bit wr_bf, wr_lw, wr_fr, first;
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: bf = pbb_pkg::CFG_DATA_W'($urandom_range(1, 4));
                6, 7:             bf = pbb_pkg::CFG_DATA_W'($urandom_range(5, 8));
                8:                bf = pbb_pkg::CFG_DATA_W'($urandom_range(0, 15)
                                       | ($urandom_range(0, 511) << 4));
                default:          bf = $urandom_range(0, 1) ? '0 : pbb_pkg::CFG_DATA_W'(15);
            endcase
            case ($urandom_range(0, 9))
                8:       lw = '0;
                9:       lw = pbb_pkg::CFG_DATA_W'($urandom_range(4097, 8191));
                default: lw = pbb_pkg::CFG_DATA_W'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 9))
                8:       fr = '0;
                9:       fr = pbb_pkg::CFG_DATA_W'($urandom_range(4097, 8191));
                default: fr = pbb_pkg::CFG_DATA_W'($urandom_range(1, 12));
            endcase
            wr_bf = first || ($urandom_range(0, 9) < 6);
            wr_lw = first || ($urandom_range(0, 9) < 6);
            wr_fr = first || ($urandom_range(0, 9) < 6);
            if (!wr_bf && !wr_lw && !wr_fr)
                wr_bf = 1'b1;
            if (wr_bf) write_reg(pbb_pkg::CFG_BIN_FACTOR, bf);
            if (wr_lw) write_reg(pbb_pkg::CFG_LINE_WIDTH, lw);
            if (wr_fr) write_reg(pbb_pkg::CFG_FRAME_ROWS, fr);
            end_config();
            first = 1'b0;

            // one or two frames and up to seven stray pixels; huge frames are capped
            n = clamp_field(cfg_width, pbb_pkg::DEF_MAX_WIDTH)
                * clamp_field(cfg_rows, pbb_pkg::MAX_ROWS)
                * $urandom_range(1, 2) + $urandom_range(0, 7);
            if (n > 240)
                n = 240;
            steady = (sent < STEADY_ITEMS);
            for (i = 0; i < n; i++) begin
                // unused index mid-frame must leave the frame position alone
                if (i == n / 2 && $urandom_range(0, 5) == 0) begin
                    wait_idle();
                    write_reg(CFG_UNUSED, pbb_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
                    end_config();
                end
                send_pixel(random_pixel());
            end
            sent += n;
        end
        steady = 1'b0;
        wait_idle();
    endtask

    // Widest line: a slice of the first row, every pixel its own result
    task automatic test_full_width();
        int i;
        set_frame(1, 4096, 4096);
        for (i = 0; i < SLICE_ITEMS; i++)
            send_pixel(random_pixel());
        wait_idle();
    endtask

    // Zero bin factor and width read as 1, rows saturate at the limit:
    // out_row counts up one per pixel
    task automatic test_full_height();
        int i;
        set_frame(0, 0, 8191);
        for (i = 0; i < SLICE_ITEMS; i++)
            send_pixel(random_pixel());
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_pix_valid   = 1'b0;
        i_pixel_value = '0;
        cfg_bin       = pbb_pkg::BF_W'(pbb_pkg::BF_RST);
        cfg_width     = pbb_pkg::LW_W'(pbb_pkg::LW_RST);
        cfg_rows      = pbb_pkg::FR_W'(pbb_pkg::FR_RST);
        restart_frame();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_pass_through();
        test_edge_and_wrap();
        test_backpressure();
        test_random_frames();
        test_full_width();
        test_full_height();
        wait_idle();

        $display("run covered %0d pixel items, %0d binned results and %0d register writes",
                 pixels_sent, results_seen, reg_writes);
        $display("bin factors 0..15, zero and saturated line widths and frame rows, stalls");
        if (errors == 0 && expected_bins.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
